[rtl/msjb_pkg.sv]
// ============================================================================
// msjb_pkg
// Shared types, sizes and result codes of the multi-stream jitter buffer.
// ============================================================================
package msjb_pkg;

  localparam int PLAYERS   = 8;
  localparam int DEPTH     = 16;
  localparam int PAYLOAD_W = 32;
  localparam int PL_W      = (PLAYERS > 1) ? $clog2(PLAYERS) : 1;
  localparam int IX_W      = $clog2(DEPTH);
  localparam int CNT_W     = IX_W + 1;
  localparam int SLOTS     = PLAYERS * DEPTH;
  localparam int SA_W      = $clog2(SLOTS);
  localparam int LB_W      = 12;
  localparam int SER_W     = 16;
  localparam int INT_W     = 16;
  localparam int RC_W      = 4;
  localparam logic [LB_W-1:0] LB_RESET = 12'd64;

  localparam logic [RC_W-1:0] RC_DELIVERED = 4'd0;
  localparam logic [RC_W-1:0] RC_PREFILL   = 4'd1;
  localparam logic [RC_W-1:0] RC_UNDERRUN  = 4'd2;
  localparam logic [RC_W-1:0] RC_DOUBLED   = 4'd3;
  localparam logic [RC_W-1:0] RC_STORED    = 4'd4;
  localparam logic [RC_W-1:0] RC_SKIPPED   = 4'd5;
  localparam logic [RC_W-1:0] RC_LATE      = 4'd6;
  localparam logic [RC_W-1:0] RC_RESYNC    = 4'd7;
  localparam logic [RC_W-1:0] RC_GAPRESET  = 4'd8;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture request and per-player state
    logic decide;   // evaluate the request, start sweep
    logic sweep;    // clear one slot of the gap
    logic finish;   // store slot for an append, update working copies
    logic rd_slot;  // registered slot read for a get
    logic result;   // build the result, commit player state
  } msjb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_done;
    logic is_get;
  } msjb_sts_t;

endpackage

[rtl/multi_stream_jitter_buffer_top.sv]
// ============================================================================
// multi_stream_jitter_buffer_top
// Per-stream jitter buffer with one slot ring per player.
// ============================================================================
//  channel | direction | ports
//  in      | input     | in_valid, in_stall, in_req_type .. in_payload
//  out     | output    | out_valid, out_stall, out_result_code .. out_prefilling
//  cfg     | input     | cfg_we, cfg_wdata (level_balance)
//
// a get passes load, read, finish and out; an append passes load, the gap
// sweep and out, clearing at most DEPTH slots; the gap sweep clears one slot a cycle
// one request in flight; in_stall is high from accept until the result is taken
// synchronous active-low reset; no clearing pass, valid bits reset at once
module multi_stream_jitter_buffer_top
  import msjb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [LB_W-1:0]   cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_req_type,
  input  logic [2:0]        in_player,
  input  logic [SER_W-1:0]  in_serial_number,
  input  logic [31:0]       in_payload,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [RC_W-1:0]   out_result_code,
  output logic              out_payload_valid,
  output logic [31:0]       out_payload_out,
  output logic              out_prefilling
);

  msjb_cmd_t cmd;
  msjb_sts_t sts;

  msjb_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  msjb_dp u_dp (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .in_req_type, .in_player,
    .in_serial_number, .in_payload, .cmd, .sts, .out_result_code,
    .out_payload_valid, .out_payload_out, .out_prefilling
  );

endmodule

[rtl/msjb_ctrl.sv]
// ============================================================================
// msjb_ctrl
// Sequencer: load, decide, gap sweep, commit, result handshake.
// ============================================================================
module msjb_ctrl
  import msjb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  msjb_sts_t sts,
  output msjb_cmd_t cmd
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_LOAD   = 7'b0000010,
    ST_DECIDE = 7'b0000100,
    ST_SWEEP  = 7'b0001000,
    ST_FINISH = 7'b0010000,
    ST_READ   = 7'b0100000,
    ST_OUT    = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.decide = 1'b1;
        state_nxt  = sts.is_get ? ST_READ : ST_SWEEP;
      end
      ST_DECIDE: state_nxt = ST_SWEEP;
      ST_SWEEP: begin
        if (sts.sweep_done) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_OUT;
        end else begin
          cmd.sweep = 1'b1;
        end
      end
      ST_READ: begin
        cmd.rd_slot = 1'b1;
        state_nxt   = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r) begin
          cmd.result    = 1'b1;
          out_valid_nxt = 1'b1;
        end else if (!out_stall) begin
          out_valid_nxt = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/msjb_dp.sv]
// ============================================================================
// msjb_dp
// Datapath: per-player state, slot memory, valid bits and result register.
// ============================================================================
module msjb_dp
  import msjb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [LB_W-1:0]      cfg_wdata,
  input  logic                 in_req_type,
  input  logic [2:0]           in_player,
  input  logic [SER_W-1:0]     in_serial_number,
  input  logic [31:0]          in_payload,
  input  msjb_cmd_t            cmd,
  output msjb_sts_t            sts,
  output logic [RC_W-1:0]      out_result_code,
  output logic                 out_payload_valid,
  output logic [31:0]          out_payload_out,
  output logic                 out_prefilling
);

  // per-player state
  logic [IX_W-1:0]         rd_ix_r  [PLAYERS];
  logic [IX_W-1:0]         wr_ix_r  [PLAYERS];
  logic [PLAYERS-1:0]      prefill_r;
  logic signed [INT_W-1:0] integ_r  [PLAYERS];
  logic [SER_W-1:0]        exp_r    [PLAYERS];
  logic [SLOTS-1:0]        full_r;
  logic [PAYLOAD_W-1:0]    mem      [SLOTS];
  logic [LB_W-1:0]         lb_r;

  // captured request and working copies
  logic                    get_r;
  logic [PL_W-1:0]         pl_r;
  logic [SER_W-1:0]        ser_r;
  logic [PAYLOAD_W-1:0]    pay_r;
  logic [IX_W-1:0]         rd_r, wr_r;
  logic                    pf_r;
  logic signed [INT_W-1:0] ig_r;
  logic [SER_W-1:0]        ex_r;
  logic [CNT_W-1:0]        left_r;     // slots still to clear
  logic [IX_W-1:0]         sw_ix_r;    // sweep address
  logic [IX_W-1:0]         gap_ix_r;   // gap mod depth, write index after a reset
  logic                    rst_ring_r; // ring reset seen
  logic [RC_W-1:0]         code_r;
  logic                    rdfull_r;
  logic [PAYLOAD_W-1:0]    rddata_r;
  logic                    pv_r;
  logic [31:0]             po_r;
  logic [RC_W-1:0]         rc_r;
  logic                    pfo_r;

  // decide-stage arithmetic
  logic [SER_W-1:0]        diff;
  logic                    late;
  logic [SER_W-1:0]        gap;
  logic [IX_W-1:0]         fill;
  logic [SER_W:0]          room;
  logic                    gap_reset;
  logic signed [INT_W+1:0] acc;
  logic signed [INT_W+1:0] dev;
  logic signed [INT_W+1:0] nlb;
  logic [PL_W-1:0]         pl_in;

  assign pl_in = PL_W'(in_player);
  assign diff  = ex_r - ser_r;
  assign late  = !diff[SER_W-1] && (diff != '0);
  assign gap   = SER_W'(-diff);
  assign fill  = wr_r - rd_r;
  assign room  = (SER_W+1)'(DEPTH) - (SER_W+1)'(fill);
  assign gap_reset = ({1'b0, gap} >= room);
  assign dev   = (INT_W+2)'($signed({1'b0, fill})) - (INT_W+2)'(DEPTH/2);
  assign acc   = (INT_W+2)'(ig_r) + dev;
  assign nlb   = -(INT_W+2)'($signed({1'b0, lb_r}));

  assign sts.sweep_done = (left_r == '0);
  assign sts.is_get     = get_r;

  assign out_result_code   = rc_r;
  assign out_payload_valid = pv_r;
  assign out_payload_out   = po_r;
  assign out_prefilling    = pfo_r;

  // slot memory, written by appends only
  always_ff @(posedge clk) begin
    if (cmd.finish && !get_r && code_r == RC_STORED)
      mem[{pl_r, wr_r}] <= pay_r;
    else if (cmd.finish && !get_r && code_r == RC_LATE)
      mem[{pl_r, IX_W'(wr_r - IX_W'(diff))}] <= pay_r;
    if (cmd.rd_slot)
      rddata_r <= mem[{pl_r, rd_r}];
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      get_r <= in_req_type;
      pl_r  <= pl_in;
      ser_r <= in_serial_number;
      pay_r <= PAYLOAD_W'(in_payload);
      rd_r  <= rd_ix_r[pl_in];
      wr_r  <= wr_ix_r[pl_in];
      pf_r  <= prefill_r[pl_in];
      ig_r  <= integ_r[pl_in];
      ex_r  <= exp_r[pl_in];
    end
    if (cmd.decide) begin
      rst_ring_r <= 1'b0;
      left_r     <= '0;
      if (get_r) begin
        if (pf_r) code_r <= RC_PREFILL;
        else if (rd_r == wr_r) begin
          code_r <= RC_UNDERRUN;
          pf_r   <= 1'b1;
        end else begin
          if (dev > 1 || dev < -1) begin
            if (acc > 32767) ig_r <= 16'sd32767;
            else if (acc < -32768) ig_r <= -16'sd32768;
            else ig_r <= INT_W'(acc);
          end
          if ((dev > 1 || dev < -1 ? (acc < nlb) : ((INT_W+2)'(ig_r) < nlb)))
            code_r <= RC_DOUBLED;
          else code_r <= RC_DELIVERED;
        end
      end else if (late) begin
        if ({1'b0, diff} < (SER_W+1)'(fill)) code_r <= RC_LATE;
        else begin
          code_r <= RC_RESYNC;
          rd_r <= '0; wr_r <= '0; pf_r <= 1'b1;
          ex_r <= ser_r;
        end
      end else begin
        gap_ix_r <= IX_W'(gap);
        if (gap_reset) begin
          rst_ring_r <= 1'b1;
          rd_r <= '0; wr_r <= '0; pf_r <= 1'b1;
          sw_ix_r <= '0;
          left_r  <= (gap < SER_W'(DEPTH)) ? CNT_W'(gap) : CNT_W'(DEPTH);
        end else begin
          sw_ix_r <= wr_r;
          left_r  <= CNT_W'(gap);
        end
        code_r <= ((INT_W+2)'(ig_r) > (INT_W+2)'($signed({1'b0, lb_r})))
                  ? RC_SKIPPED : RC_STORED;
        ex_r   <= ser_r + 1'b1;
      end
    end
    // one slot per cycle; final write index after a reset is gap mod depth
    if (cmd.sweep) begin
      sw_ix_r <= sw_ix_r + 1'b1;
      left_r  <= left_r - 1'b1;
      if (left_r == CNT_W'(1))
        wr_r <= rst_ring_r ? gap_ix_r : IX_W'(sw_ix_r + 1'b1);
    end
    if (cmd.rd_slot) rdfull_r <= full_r[{pl_r, rd_r}];
    if (cmd.finish) begin
      if (get_r) begin
        if (code_r == RC_DOUBLED) ig_r <= '0;
        if (code_r == RC_DELIVERED) rd_r <= rd_r + 1'b1;
      end else if (code_r == RC_STORED) begin
        if (IX_W'(wr_r + 1'b1) == rd_r) begin
          rd_r <= '0; wr_r <= '0; pf_r <= 1'b1;
          rst_ring_r <= 1'b1;
        end else begin
          wr_r <= wr_r + 1'b1;
        end
      end else if (code_r == RC_SKIPPED) begin
        ig_r <= '0;
      end
    end
  end

  // result register, built after commit
  always_ff @(posedge clk) begin
    if (cmd.result) begin
      pv_r <= 1'b0;
      po_r <= '0;
      if (get_r) begin
        rc_r  <= code_r;
        pfo_r <= pf_r;
        if (code_r == RC_DELIVERED && rdfull_r) begin
          pv_r <= 1'b1;
          po_r <= 32'(rddata_r);
        end
      end else begin
        rc_r  <= (rst_ring_r && (code_r == RC_STORED || code_r == RC_SKIPPED))
                 ? RC_GAPRESET : code_r;
        pfo_r <= pf_r && !(IX_W'(wr_r - rd_r) >= IX_W'(DEPTH/2));
      end
    end
  end

  // per-player state, valid bits and register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r    <= '0;
      prefill_r <= '1;
      lb_r      <= LB_RESET;
      for (int i = 0; i < PLAYERS; i++) begin
        rd_ix_r[i] <= '0;
        wr_ix_r[i] <= '0;
        integ_r[i] <= '0;
        exp_r[i]   <= '0;
      end
    end else begin
      if (cfg_we) lb_r <= cfg_wdata;
      if (cmd.sweep) full_r[{pl_r, sw_ix_r}] <= 1'b0;
      if (cmd.finish && !get_r && code_r == RC_STORED)
        full_r[{pl_r, wr_r}] <= 1'b1;
      if (cmd.finish && !get_r && code_r == RC_LATE)
        full_r[{pl_r, IX_W'(wr_r - IX_W'(diff))}] <= 1'b1;
      if (cmd.result) begin
        rd_ix_r[pl_r]   <= rd_r;
        wr_ix_r[pl_r]   <= wr_r;
        integ_r[pl_r]   <= ig_r;
        exp_r[pl_r]     <= ex_r;
        prefill_r[pl_r] <= get_r ? pf_r
                           : (pf_r && !(IX_W'(wr_r - rd_r) >= IX_W'(DEPTH/2)));
      end
    end
  end

endmodule

[rtl/msjb_chk.sv]
// ============================================================================
// msjb_chk
// Port-level checks of the jitter buffer, bound to the top level.
// ============================================================================
module msjb_chk
  import msjb_pkg::*;
(
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input logic [RC_W-1:0] out_result_code,
  input logic            out_payload_valid,
  input logic [31:0]     out_payload_out
);

  // result holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_code))
    else $error("result changed under stall");

  // only a delivery carries a payload
  a_pv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload_valid |-> out_result_code == RC_DELIVERED)
    else $error("payload on non-delivery");

  // empty results carry zero
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_payload_valid |-> out_payload_out == '0)
    else $error("nonzero empty payload");

  // no new request while a result waits
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("request taken with result pending");

  // a taken request is followed by a stall
  a_acc: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("no stall after accept");

endmodule

bind multi_stream_jitter_buffer_top msjb_chk u_chk (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
  .out_result_code, .out_payload_valid, .out_payload_out
);

[sim/tb_multi_stream_jitter_buffer_top.sv]
// ============================================================================
// tb_multi_stream_jitter_buffer_top
// Self-checking bench for the multi-stream jitter buffer: a cycle-free
// predictor of each player ring tracks every accepted request and the
// checker compares each result field by field under random valid/stall gaps.
// ============================================================================
module tb_multi_stream_jitter_buffer_top;
  import msjb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 30;

  typedef struct packed {
    logic [RC_W-1:0] code;
    logic            pay_valid;
    logic [31:0]     pay;
    logic            prefill;
  } jb_result_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [LB_W-1:0]   cfg_wdata;
  logic              in_valid;
  logic              in_stall;
  logic              in_req_type;
  logic [2:0]        in_player;
  logic [SER_W-1:0]  in_serial_number;
  logic [31:0]       in_payload;
  logic              out_valid;
  logic              out_stall;
  logic [RC_W-1:0]   out_result_code;
  logic              out_payload_valid;
  logic [31:0]       out_payload_out;
  logic              out_prefilling;

  // predicted state of every ring
  logic [31:0]       ring_data [SLOTS];
  bit                ring_full [SLOTS];
  logic [IX_W-1:0]   rd_ix [PLAYERS];
  logic [IX_W-1:0]   wr_ix [PLAYERS];
  bit                prefill_st [PLAYERS];
  int                fill_acc [PLAYERS];
  logic [15:0]       next_serial [PLAYERS];
  int                balance_lim;

  jb_result_t        pending_results [$];
  int                errors;
  int                n_requests;
  int                code_seen [9];
  int                snd_idle_pct;
  int                rcv_idle_pct;
  int                hold_off;
  int                idle_cycles;

  multi_stream_jitter_buffer_top u_dut (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int ring_fill(int p);
    logic [IX_W-1:0] f;
    f = wr_ix[p] - rd_ix[p];
    return int'(f);
  endfunction

  function automatic void ring_clear(int p);
    prefill_st[p] = 1'b1;
    wr_ix[p] = '0;
    rd_ix[p] = '0;
  endfunction

  // expected result of one request, updates the predicted ring state
  function automatic jb_result_t jb_predict(bit is_get, int p, logic [15:0] ser,
                                            logic [31:0] pay);
    jb_result_t r;
    logic [15:0] diff;
    int age, gap, n, dev, acc;
    bit was_reset;
    r = '0;
    if (!is_get) begin
      diff = next_serial[p] - ser;
      age = (diff >= 16'd32768) ? int'(diff) - 65536 : int'(diff);
      if (age <= 0) begin
        gap = -age;
        was_reset = 0;
        if (gap >= DEPTH - ring_fill(p)) begin
          n = (gap < DEPTH) ? gap : DEPTH;
          ring_clear(p);
          for (int i = 0; i < n; i++) ring_full[p*DEPTH + i] = 0;
          wr_ix[p] = gap % DEPTH;
          was_reset = 1;
        end else begin
          for (int i = 0; i < gap; i++) begin
            ring_full[p*DEPTH + wr_ix[p]] = 0;
            wr_ix[p] = wr_ix[p] + 1'b1;
          end
        end
        if (fill_acc[p] > balance_lim) begin
          fill_acc[p] = 0;
          r.code = RC_SKIPPED;
        end else begin
          ring_full[p*DEPTH + wr_ix[p]] = 1;
          ring_data[p*DEPTH + wr_ix[p]] = pay;
          wr_ix[p] = wr_ix[p] + 1'b1;
          if (wr_ix[p] == rd_ix[p]) begin
            ring_clear(p);
            was_reset = 1;
          end
          r.code = RC_STORED;
        end
        if (was_reset) r.code = RC_GAPRESET;
        next_serial[p] = ser + 16'd1;
      end else if (age < ring_fill(p)) begin
        n = p*DEPTH + int'(IX_W'(wr_ix[p] - IX_W'(age)));
        ring_full[n] = 1;
        ring_data[n] = pay;
        r.code = RC_LATE;
      end else begin
        ring_clear(p);
        next_serial[p] = ser;
        r.code = RC_RESYNC;
      end
      if (ring_fill(p) >= DEPTH/2) prefill_st[p] = 0;
    end else if (prefill_st[p]) begin
      r.code = RC_PREFILL;
    end else if (rd_ix[p] == wr_ix[p]) begin
      prefill_st[p] = 1;
      r.code = RC_UNDERRUN;
    end else begin
      dev = ring_fill(p) - DEPTH/2;
      if (dev > 1 || dev < -1) begin
        acc = fill_acc[p] + dev;
        if (acc > 32767) acc = 32767;
        if (acc < -32768) acc = -32768;
        fill_acc[p] = acc;
      end
      if (fill_acc[p] < -balance_lim) begin
        fill_acc[p] = 0;
        r.code = RC_DOUBLED;
      end else begin
        if (ring_full[p*DEPTH + rd_ix[p]]) begin
          r.pay_valid = 1;
          r.pay = ring_data[p*DEPTH + rd_ix[p]];
        end
        rd_ix[p] = rd_ix[p] + 1'b1;
        r.code = RC_DELIVERED;
      end
    end
    r.prefill = prefill_st[p];
    return r;
  endfunction

  // send one request, predict it at the accepting edge
  task automatic send_req(bit is_get, int p, logic [15:0] ser, logic [31:0] pay);
    @(negedge clk);
    if ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_req_type = is_get;
    in_player = p[2:0];
    in_serial_number = ser;
    in_payload = pay;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(jb_predict(is_get, p, ser, pay));
    n_requests++;
  endtask

  task automatic append_next(int p, int skip_ahead);
    send_req(0, p, next_serial[p] + 16'(skip_ahead), $urandom);
  endtask

  // register write only with the block idle
  task automatic set_balance(logic [LB_W-1:0] v);
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    balance_lim = int'(v);
  endtask

  // random traffic, mostly in-order streams with some loss, lateness and noise
  task automatic random_traffic(int count);
    int p, r;
    for (int k = 0; k < count; k++) begin
      p = $urandom_range(0, PLAYERS-1);
      r = $urandom_range(0, 99);
      if (r < 42) send_req(1, p, 16'($urandom), $urandom);
      else if (r < 82) append_next(p, 0);
      else if (r < 89) append_next(p, $urandom_range(1, 4));
      else if (r < 95) append_next(p, -$urandom_range(1, 6));
      else if (r < 98) append_next(p, $urandom_range(5, 40));
      else send_req(0, p, 16'($urandom), $urandom);
    end
  endtask

  task automatic test_prefill_and_delivery();
    send_req(1, 0, 16'h0000, 32'h0);          // get while prefilling
    send_req(0, 0, 16'h0000, 32'hFFFF_FFFF);
    for (int i = 0; i < 8; i++) append_next(0, 0);
    for (int i = 0; i < 4; i++) send_req(1, 0, 16'hFFFF, 32'h0);
    send_req(0, 7, 16'hFFFF, 32'h0000_0000);  // serial wrap on the top player
    append_next(7, 0);
  endtask

  task automatic test_gaps_and_late();
    append_next(0, 2);                        // lost serials become empty slots
    append_next(0, -2);                       // late packet into its own slot
    append_next(0, -15);                      // too late, resync
    for (int i = 0; i < 9; i++) append_next(0, 0);
    for (int i = 0; i < 10; i++) send_req(1, 0, 16'h0, 32'h0); // through to underrun
    append_next(3, 100);                      // large gap resets the ring
    for (int i = 0; i < 16; i++) append_next(3, 0); // overrun
  endtask

  task automatic test_backpressure();
    hold_off = 300;
    random_traffic(30);
  endtask

  task automatic test_drain_pause();
    random_traffic(40);
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending_results.size() == 0);
    random_traffic(40);
  endtask

  // result checker
  always @(posedge clk) begin
    jb_result_t exp_r, got_r;
    if (rst_n && out_valid && !out_stall) begin
      got_r = '{out_result_code, out_payload_valid, out_payload_out, out_prefilling};
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, got_r);
      end else begin
        exp_r = pending_results.pop_front();
        if (got_r.code <= RC_GAPRESET) code_seen[got_r.code]++;
        if (got_r.code != exp_r.code) begin
          errors++;
          $display("%0t: result_code exp %0d got %0d", $time, exp_r.code, got_r.code);
        end
        if (got_r.pay_valid != exp_r.pay_valid) begin
          errors++;
          $display("%0t: payload_valid exp %0d got %0d", $time, exp_r.pay_valid,
                   got_r.pay_valid);
        end
        if (got_r.pay != exp_r.pay) begin
          errors++;
          $display("%0t: payload_out exp %h got %h", $time, exp_r.pay, got_r.pay);
        end
        if (got_r.prefill != exp_r.prefill) begin
          errors++;
          $display("%0t: prefilling exp %0d got %0d", $time, exp_r.prefill,
                   got_r.prefill);
        end
      end
    end
  end

  // receiver stall, with an occasional long hold-off
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
    end
  end

  // watchdog on cycles without any accepted request or result
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else if (rst_n) begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_multi_stream_jitter_buffer_top NOT OK");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_req_type = 1'b0;
    in_player = '0;
    in_serial_number = '0;
    in_payload = '0;
    out_stall = 1'b0;
    errors = 0;
    n_requests = 0;
    hold_off = 0;
    idle_cycles = 0;
    balance_lim = int'(LB_RESET);
    for (int i = 0; i < SLOTS; i++) begin
      ring_full[i] = 0;
      ring_data[i] = '0;
    end
    for (int p = 0; p < PLAYERS; p++) begin
      rd_ix[p] = '0;
      wr_ix[p] = '0;
      prefill_st[p] = 1;
      fill_acc[p] = 0;
      next_serial[p] = '0;
    end
    snd_idle_pct = 35;
    rcv_idle_pct = 76;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_prefill_and_delivery();
    test_gaps_and_late();
    random_traffic(200);
    set_balance(12'd0);
    random_traffic(200);
    snd_idle_pct = 76;
    rcv_idle_pct = 35;
    set_balance(12'd4095);
    random_traffic(150);
    set_balance(12'd3);
    test_backpressure();
    random_traffic(150);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    set_balance(12'($urandom_range(1, 40)));
    test_drain_pause();
    set_balance(LB_RESET);
    random_traffic(200);

    @(negedge clk);
    in_valid = 1'b0;
    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d requests over five level_balance settings", n_requests);
    $display("codes: dlv %0d pre %0d und %0d dbl %0d sto %0d skp %0d late %0d rsy %0d gap %0d",
             code_seen[0], code_seen[1], code_seen[2], code_seen[3], code_seen[4],
             code_seen[5], code_seen[6], code_seen[7], code_seen[8]);
    if (errors == 0 && pending_results.size() == 0)
      $display("tb_multi_stream_jitter_buffer_top OK");
    else
      $display("tb_multi_stream_jitter_buffer_top NOT OK");
    $finish;
  end

endmodule
